@@ rtl/expr_lex_pkg.sv @@
// Package for the expression scanner: scanner modes, token kinds, character
// codes, the token record and character-class helpers.
// No dependencies.
package expr_lex_pkg;

  localparam int DEF_POS_BITS  = 16;
  localparam int DEF_LINE_BITS = 16;

  // Output field widths are fixed by the token format.
  localparam int TOK_W  = 16;
  localparam int KIND_W = 5;

  typedef logic [KIND_W-1:0] kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_INT,
    MODE_DOT,
    MODE_FRAC
  } lex_mode_t;

  localparam kind_t KIND_EOF    = 5'd0;
  localparam kind_t KIND_ERROR  = 5'd1;
  localparam kind_t KIND_IDENT  = 5'd2;
  localparam kind_t KIND_NUMBER = 5'd3;
  localparam kind_t KIND_VAR_X  = 5'd4;
  localparam kind_t KIND_LPAREN = 5'd7;
  localparam kind_t KIND_RPAREN = 5'd8;
  localparam kind_t KIND_PLUS   = 5'd9;
  localparam kind_t KIND_MINUS  = 5'd10;
  localparam kind_t KIND_STAR   = 5'd11;
  localparam kind_t KIND_SLASH  = 5'd12;
  localparam kind_t KIND_CARET  = 5'd13;
  localparam kind_t KIND_COMMA  = 5'd14;
  localparam kind_t KIND_LESS   = 5'd15;
  localparam kind_t KIND_GREATER = 5'd16;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_Z     = 8'h7A;

  typedef struct packed {
    kind_t            kind;
    logic [TOK_W-1:0] start;
    logic [TOK_W-1:0] length;
    logic [TOK_W-1:0] line;
  } token_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_numeral(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic kind_t single_kind(input logic [7:0] c);
    kind_t k;
    unique case (c)
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h2B:   k = KIND_PLUS;
      8'h2D:   k = KIND_MINUS;
      8'h2A:   k = KIND_STAR;
      8'h2F:   k = KIND_SLASH;
      8'h5E:   k = KIND_CARET;
      8'h2C:   k = KIND_COMMA;
      8'h3C:   k = KIND_LESS;
      8'h3E:   k = KIND_GREATER;
      default: k = KIND_ERROR;
    endcase
    return k;
  endfunction

endpackage

@@ rtl/expression_lexer_unit.sv @@
// Expression scanner top level: input byte register, scanner state and
// token decode, three-entry token buffer.
// Depends on expr_lex_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall / text_byte) carries one text byte per
//   request; a zero byte ends the text. Output channel (out_valid / out_stall
//   / token_*) carries one token per request; last_of_run marks the final
//   token caused by one input byte.
//   Path: a byte taken into the input register is decoded into the token
//   buffer once the buffer is free, and its tokens are shown from there.
//   Throughput: one byte per cycle while each byte yields at most one token
//   and the receiver takes tokens as they come. A byte that yields two or
//   three tokens (number closed by a dot with no digit, or a token flushed
//   ahead of EOF / an operator) holds the decode until the last of its tokens
//   is being taken, since the buffer drains one token per cycle.
//   Reset: offset 0, line 1, scanner idle, input register and token buffer
//   empty. A zero byte restarts the same way after its EOF token.
//   Receiver stall: tokens wait in the buffer; the one input register still
//   takes a byte, then in_stall rises until the buffer frees.
module expression_lexer_unit #(
  parameter int POS_BITS  = expr_lex_pkg::DEF_POS_BITS,
  parameter int LINE_BITS = expr_lex_pkg::DEF_LINE_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          text_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output expr_lex_pkg::kind_t                 token_kind,
  output logic [expr_lex_pkg::TOK_W-1:0]      token_start,
  output logic [expr_lex_pkg::TOK_W-1:0]      token_length,
  output logic [expr_lex_pkg::TOK_W-1:0]      token_line,
  output logic                                last_of_run
);
  import expr_lex_pkg::*;

  // Input register
  logic       in_full;
  logic [7:0] in_byte;

  // Scanner state
  lex_mode_t             mode, mode_next;
  logic [POS_BITS-1:0]   byte_position, byte_position_next;
  logic [LINE_BITS-1:0]  line_count, line_count_next;
  logic [POS_BITS-1:0]   pending_start, pending_start_next;
  logic [POS_BITS-1:0]   dot_offset, dot_offset_next;
  logic [7:0]            first_letter, first_letter_next;
  logic                  single_letter, single_letter_next;

  // Token buffer: loaded whole, drained from head
  token_t     slots [3];
  logic [1:0] cnt;
  logic [1:0] head;

  token_t     toks [3];
  logic [1:0] n_tok;

  logic advance;
  logic out_take;

  assign out_valid = (cnt != 2'd0);
  assign out_take  = out_valid && !out_stall;
  // Decode only into a buffer that is empty, or emptied by this cycle's take.
  assign advance   = in_full && ((cnt == 2'd0) || ((cnt == 2'd1) && !out_stall));
  assign in_stall  = in_full && !advance;

  assign token_kind   = slots[head].kind;
  assign token_start  = slots[head].start;
  assign token_length = slots[head].length;
  assign token_line   = slots[head].line;
  assign last_of_run  = (cnt == 2'd1);

  // Token decode and next state for the byte held in the input register.
  always_comb begin
    logic             taken;
    logic             restart;
    kind_t            id_kind;
    logic [TOK_W-1:0] line16;
    logic [TOK_W-1:0] pos16;

    taken   = 1'b0;
    restart = 1'b0;
    n_tok   = 2'd0;
    for (int i = 0; i < 3; i++) begin
      toks[i] = '0;
    end
    line16 = TOK_W'(line_count);
    pos16  = TOK_W'(byte_position);

    mode_next          = mode;
    byte_position_next = byte_position;
    line_count_next    = line_count;
    pending_start_next = pending_start;
    dot_offset_next    = dot_offset;
    first_letter_next  = first_letter;
    single_letter_next = single_letter;

    id_kind = KIND_IDENT;
    if (single_letter && first_letter >= CH_X && first_letter <= CH_Z) begin
      id_kind = KIND_VAR_X + KIND_W'(first_letter - CH_X);
    end

    // Close a pending identifier or number.
    unique case (mode)
      MODE_IDENT: begin
        if (is_letter(in_byte) || is_numeral(in_byte)) begin
          single_letter_next = 1'b0;
          taken = 1'b1;
        end else begin
          toks[0] = '{id_kind, TOK_W'(pending_start),
                      TOK_W'(byte_position - pending_start), line16};
          n_tok = 2'd1;
          mode_next = MODE_IDLE;
        end
      end
      MODE_INT: begin
        if (is_numeral(in_byte)) begin
          taken = 1'b1;
        end else if (in_byte == CH_DOT) begin
          dot_offset_next = byte_position;
          mode_next = MODE_DOT;
          taken = 1'b1;
        end else begin
          toks[0] = '{KIND_NUMBER, TOK_W'(pending_start),
                      TOK_W'(byte_position - pending_start), line16};
          n_tok = 2'd1;
          mode_next = MODE_IDLE;
        end
      end
      MODE_DOT: begin
        if (is_numeral(in_byte)) begin
          mode_next = MODE_FRAC;
          taken = 1'b1;
        end else begin
          // Number ends before the dot; the lone dot is an error token.
          toks[0] = '{KIND_NUMBER, TOK_W'(pending_start),
                      TOK_W'(dot_offset - pending_start), line16};
          toks[1] = '{KIND_ERROR, TOK_W'(dot_offset), TOK_W'(1), line16};
          n_tok = 2'd2;
          mode_next = MODE_IDLE;
        end
      end
      MODE_FRAC: begin
        if (is_numeral(in_byte)) begin
          taken = 1'b1;
        end else begin
          toks[0] = '{KIND_NUMBER, TOK_W'(pending_start),
                      TOK_W'(byte_position - pending_start), line16};
          n_tok = 2'd1;
          mode_next = MODE_IDLE;
        end
      end
      default: mode_next = MODE_IDLE;
    endcase

    // The byte itself, when the pending token did not absorb it.
    if (!taken) begin
      priority if (in_byte == CH_NUL) begin
        toks[n_tok] = '{KIND_EOF, pos16, TOK_W'(0), line16};
        n_tok = n_tok + 2'd1;
        restart = 1'b1;
      end else if (in_byte == CH_SPACE || in_byte == CH_TAB || in_byte == CH_CR) begin
        // whitespace
      end else if (in_byte == CH_NL) begin
        if (line_count != {LINE_BITS{1'b1}}) begin
          line_count_next = line_count + 1'b1;
        end
      end else if (is_letter(in_byte)) begin
        mode_next          = MODE_IDENT;
        pending_start_next = byte_position;
        first_letter_next  = in_byte;
        single_letter_next = 1'b1;
      end else if (is_numeral(in_byte)) begin
        mode_next          = MODE_INT;
        pending_start_next = byte_position;
      end else begin
        toks[n_tok] = '{single_kind(in_byte), pos16, TOK_W'(1), line16};
        n_tok = n_tok + 2'd1;
      end
    end

    if (restart) begin
      mode_next          = MODE_IDLE;
      byte_position_next = '0;
      line_count_next    = LINE_BITS'(1);
      pending_start_next = '0;
      dot_offset_next    = '0;
      first_letter_next  = '0;
      single_letter_next = 1'b0;
    end else if (byte_position != {POS_BITS{1'b1}}) begin
      byte_position_next = byte_position + 1'b1;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
    if (!in_stall && in_valid) begin
      in_byte <= text_byte;
    end
  end

  // Scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      byte_position <= '0;
      line_count    <= LINE_BITS'(1);
      pending_start <= '0;
      dot_offset    <= '0;
      first_letter  <= '0;
      single_letter <= 1'b0;
    end else if (advance) begin
      mode          <= mode_next;
      byte_position <= byte_position_next;
      line_count    <= line_count_next;
      pending_start <= pending_start_next;
      dot_offset    <= dot_offset_next;
      first_letter  <= first_letter_next;
      single_letter <= single_letter_next;
    end
  end

  // Token buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= 2'd0;
      head <= 2'd0;
    end else if (advance) begin
      cnt  <= n_tok;
      head <= 2'd0;
    end else if (out_take) begin
      cnt  <= cnt - 2'd1;
      head <= head + 2'd1;
    end
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        slots[i] <= toks[i];
      end
    end
  end

  // Checks
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    advance |-> (cnt == 2'd0) || ((cnt == 2'd1) && out_take))
    else $error("token buffer loaded while holding untaken tokens");

  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == KIND_EOF |-> last_of_run)
    else $error("EOF token not last of its run");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    advance && in_byte == CH_NUL |=> byte_position == '0 && mode == MODE_IDLE
      && line_count == LINE_BITS'(1))
    else $error("scanner did not restart after end of text");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    line_count != '0)
    else $error("line count reached zero");

endmodule
